FILE: sv/ole_pkg.sv
package ole_pkg;

  // Result position field width
  localparam int POS_W = 5;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    FN_INS_FRONT  = 3'd0,
    FN_INS_END    = 3'd1,
    FN_INS_AFTER  = 3'd2,
    FN_INS_BEFORE = 3'd3,
    FN_DELETE     = 3'd4,
    FN_SEARCH     = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_COUNT, PTR_INC, PTR_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    POS_HOLD, POS_ZERO, POS_COUNT, POS_PTR, POS_PTR1
  } pos_op_t;

  typedef enum logic [1:0] {
    RD_PTR, RD_PREV, RD_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_MOVE, WR_VALUE
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    pos_op_t pos_op;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    res_load;
    status_t res_status;
    logic    res_pos;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  match;
    logic  at_pos;
    logic  at_last;
  } sts_t;

endpackage

FILE: sv/ole_if.sv
// Request channel: one list operation per transaction
interface ole_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  func;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

// Response channel: one result per transaction
interface ole_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] position;

  modport source (output valid, status, position, input ready);
  modport sink   (input valid, status, position, output ready);
endinterface

FILE: sv/ordered_list_engine_top.sv
// Ordered list engine: holds up to DEPTH signed 32-bit entries in list order
// and applies one operation per request transaction (insert front, insert end,
// insert after or before the first entry equal to key, delete, search),
// answering with one response transaction carrying status and the 1-based
// search position. All entries sit in one memory with a single write port and
// a registered read port, so everything is sequenced through that port: a
// keyed operation scans entry by entry (read, then compare) up to and including
// the match, and an insert or delete then moves the entries behind the point of
// change one by one, plus a closing step that writes the new entry or drops the
// count. Every operation also passes through capture, decode and result
// hand-off; insert before and delete are the worst case, where scan and moves
// together cover the whole list. The hand-off waits for the previous response
// to leave. One request is worked on at a time; a new one is taken while the
// previous response still waits in the output register.
module ordered_list_engine_top
  import ole_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  ole_req_if.sink   req,
  ole_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .func     (req.func),
    .key      (req.key),
    .value    (req.value),
    .status   (rsp.status),
    .position (rsp.position)
  );

endmodule

FILE: sv/ole_ctrl.sv
module ole_ctrl
  import ole_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CMP, S_INS_CHK, S_INS_MV,
    S_DEL_CHK, S_DEL_MV, S_FINISH
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_INS_FRONT, FN_INS_END: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_FINISH;
            end else begin
              cmd.pos_op = (sts.func == FN_INS_FRONT) ? POS_ZERO : POS_COUNT;
              cmd.ptr_op = PTR_COUNT;
              state_next = S_INS_CHK;
            end
          end
          FN_INS_AFTER, FN_INS_BEFORE, FN_DELETE, FN_SEARCH: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_FINISH;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = S_SCAN_RD;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            state_next   = S_FINISH;
          end
        endcase
      end
      // Read the entry under the pointer
      S_SCAN_RD: begin
        cmd.rd_sel = RD_PTR;
        state_next = S_SCAN_CMP;
      end
      // Compare it against the key
      S_SCAN_CMP: begin
        if (sts.match) begin
          priority case (sts.func)
            FN_SEARCH: begin
              cmd.res_load = 1'b1;
              cmd.res_pos  = 1'b1;
              state_next   = S_FINISH;
            end
            FN_DELETE: begin
              state_next = S_DEL_CHK;
            end
            default: begin
              if (sts.full) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_FULL;
                state_next     = S_FINISH;
              end else begin
                cmd.pos_op = (sts.func == FN_INS_AFTER) ? POS_PTR1 : POS_PTR;
                cmd.ptr_op = PTR_COUNT;
                state_next = S_INS_CHK;
              end
            end
          endcase
        end else if (sts.at_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_next     = S_FINISH;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_SCAN_RD;
        end
      end
      // Insert: move entries up one place from the tail down to the gap
      S_INS_CHK: begin
        if (sts.at_pos) begin
          cmd.wr_op    = WR_VALUE;
          cmd.cnt_op   = CNT_INC;
          cmd.res_load = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_MV;
        end
      end
      S_INS_MV: begin
        cmd.wr_op  = WR_MOVE;
        cmd.ptr_op = PTR_DEC;
        state_next = S_INS_CHK;
      end
      // Delete: close the gap by moving the entries behind it down
      S_DEL_CHK: begin
        if (sts.at_last) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.res_load = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.rd_sel = RD_NEXT;
          state_next = S_DEL_MV;
        end
      end
      S_DEL_MV: begin
        cmd.wr_op  = WR_MOVE;
        cmd.ptr_op = PTR_INC;
        state_next = S_DEL_CHK;
      end
      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/ole_dp.sv
module ole_dp
  import ole_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic        [2:0]  func,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic        [1:0]  status,
  output logic [POS_W-1:0]   position
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic        [2:0]  func_q;
  logic signed [31:0] key_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;
  logic [31:0]        store [DEPTH];
  logic [31:0]        ptr_inc;
  status_t            res_status;
  logic [POS_W-1:0]   res_pos;

  assign ptr_inc = 32'(ptr) + 32'd1;

  // Status toward the controller
  assign sts.func    = func_t'(func_q);
  assign sts.empty   = (count == '0);
  assign sts.full    = (count == CW'(DEPTH));
  assign sts.match   = (rd_data == key_q);
  assign sts.at_pos  = (ptr == pos);
  assign sts.at_last = ((CW'(ptr) + CW'(1)) == count);

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_addr = ptr - AW'(1);
      RD_NEXT: rd_addr = ptr + AW'(1);
      default: rd_addr = ptr;
    endcase
  end

  // Entry memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_op == WR_MOVE) begin
      store[ptr] <= rd_data;
    end else if (cmd.wr_op == WR_VALUE) begin
      store[ptr] <= value_q;
    end
    rd_data <= store[rd_addr];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Item capture, pointer, insert position, results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      key_q   <= key;
      value_q <= value;
    end
    unique case (cmd.ptr_op)
      PTR_ZERO:  ptr <= '0;
      PTR_COUNT: ptr <= count[AW-1:0];
      PTR_INC:   ptr <= ptr + AW'(1);
      PTR_DEC:   ptr <= ptr - AW'(1);
      default:   ptr <= ptr;
    endcase
    unique case (cmd.pos_op)
      POS_ZERO:  pos <= '0;
      POS_COUNT: pos <= count[AW-1:0];
      POS_PTR:   pos <= ptr;
      POS_PTR1:  pos <= ptr_inc[AW-1:0];
      default:   pos <= pos;
    endcase
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_pos    <= cmd.res_pos ? ptr_inc[POS_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      status   <= res_status;
      position <= res_pos;
    end
  end

endmodule

FILE: sv/ole_checker.sv
module ole_checker
  import ole_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [4:0] rsp_position
);

  // Only a successful search reports a position
  a_pos_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_position != '0) |-> (rsp_status == ST_DONE))
    else $error("position reported with non-done status");

  // One request in flight: busy right after a request transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in work");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_status) && $stable(rsp_position))
    else $error("stalled response changed");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position)
);
